### design/usm_pkg.sv
// Shared constants and types for the 3x3 box unsharp-mask sharpener.
// Holds geometry limits, register indexes, reset values and the divide-by-9
// reciprocal. No dependencies.
`default_nettype none

package usm_pkg;

  localparam int MAX_LINE_DEF = 1024;

  localparam int PIX_W     = 8;
  localparam int COORD_W   = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int GAIN_W    = 8;
  localparam int SUM_W     = 12;

  // Stream widths: tdata is byte-padded
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARPEN_GAIN = 2'd2;

  localparam logic [CFG_W-1:0]  LINE_WIDTH_RST = 11'd512;
  localparam logic [CFG_W-1:0]  FRAME_ROWS_RST = 11'd512;
  localparam logic [GAIN_W-1:0] GAIN_RST       = 8'd23;

  // floor(x/9) == (x * 3641) >> 15 for every x up to 9*255
  localparam logic [SUM_W-1:0] DIV9_MUL   = 12'd3641;
  localparam int               DIV9_SHIFT = 15;

  // Which of the up to four results an item produces, lowest bit first:
  // centre pixel, right edge of the row above, last row, bottom-right corner
  typedef struct packed {
    logic [3:0] sel;
    logic       inner;
  } res_sel_t;

endpackage

`default_nettype wire

### design/unsharp_mask_3x3_box.sv
// Throughput: one pixel per cycle; the results of a pixel leave one after another,
// and the input stalls while a group of results is still draining.
// The line memory (one read, one write port, registered read) lets a new pixel be
// read while the previous one is written.
// Reset: asynchronous, clears counters, window, pipeline and registers to defaults;
// the line memory is not cleared and needs no clearing pass.
`default_nettype none

module unsharp_mask_3x3_box #(
  parameter int MAX_LINE = usm_pkg::MAX_LINE_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [usm_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [usm_pkg::CFG_W-1:0]     cfg_wdata_i,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [usm_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [7:0] pixel_in
  // output stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [usm_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // [7:0] pixel_out,
                                                            // [17:8] out_row,
                                                            // [27:18] out_col, rest 0
  output logic                               m_axis_tlast   // last_of_run
);
  import usm_pkg::*;

  localparam int CW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int MW = 2 * PIX_W;

  function automatic logic [CW-1:0] geom_last(input logic [CFG_W-1:0] v);
    int unsigned e;
    e = 32'(v);
    if (e < 3) e = 3;
    if (e > MAX_LINE) e = MAX_LINE;
    return CW'(e - 1);
  endfunction

  function automatic logic [COORD_W-1:0] coord(input logic [CW-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[COORD_W-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [CW-1:0]     wlast_q, hlast_q;
  logic [GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= geom_last(LINE_WIDTH_RST);
      hlast_q <= geom_last(FRAME_ROWS_RST);
      gain_q  <= GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_LINE_WIDTH:   wlast_q <= geom_last(cfg_wdata_i);
        CFG_FRAME_ROWS:   hlast_q <= geom_last(cfg_wdata_i);
        CFG_SHARPEN_GAIN: gain_q  <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  logic adv;
  logic accept;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // ---------------------------------------------------------------- position
  logic [CW-1:0] col_q, row_q;
  logic          restart;
  assign restart = cfg_we_i && (cfg_addr_i == CFG_LINE_WIDTH || cfg_addr_i == CFG_FRAME_ROWS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_q == wlast_q) begin
        col_q <= '0;
        row_q <= (row_q == hlast_q) ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  res_sel_t sel0;
  always_comb begin
    sel0.sel[0] = (row_q != '0) && (col_q != '0);
    sel0.sel[1] = (row_q != '0) && (col_q == wlast_q);
    sel0.sel[2] = (row_q == hlast_q) && (col_q != '0);
    sel0.sel[3] = (row_q == hlast_q) && (col_q == wlast_q);
    sel0.inner  = (row_q > CW'(1)) && (col_q > CW'(1));
  end

  // ---------------------------------------------------------------- line memory
  // Each entry holds {older line, recent line} for one column.
  logic [MW-1:0]    line_mem [MAX_LINE];
  logic [MW-1:0]    rd_q;
  logic [PIX_W-1:0] pix1_q;
  logic [CW-1:0]    r1_q, c1_q;
  res_sel_t         sel1_q;
  logic             v1_q;
  logic             mem_we;

  assign mem_we = v1_q && adv;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[col_q];
    end
    if (mem_we) begin
      line_mem[c1_q] <= {rd_q[PIX_W-1:0], pix1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix1_q <= s_axis_tdata[PIX_W-1:0];
      r1_q   <= row_q;
      c1_q   <= col_q;
      sel1_q <= sel0;
    end
  end

  // ---------------------------------------------------------------- window
  logic [PIX_W-1:0] win_q [9];
  logic [CW-1:0]    r2_q, c2_q;
  res_sel_t         sel2_q;
  logic             v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (mem_we) begin
      // shift left, load the new column
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[2] <= rd_q[MW-1:PIX_W];
      win_q[5] <= rd_q[PIX_W-1:0];
      win_q[8] <= pix1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r2_q   <= r1_q;
      c2_q   <= c1_q;
      sel2_q <= sel1_q;
    end
  end

  // ---------------------------------------------------------------- window sum
  logic [SUM_W-1:0] top_s, mid_s, bot_s, sum2;
  assign top_s = SUM_W'(win_q[0]) + SUM_W'(win_q[1]) + SUM_W'(win_q[2]);
  assign mid_s = SUM_W'(win_q[3]) + SUM_W'(win_q[4]) + SUM_W'(win_q[5]);
  assign bot_s = SUM_W'(win_q[6]) + SUM_W'(win_q[7]) + SUM_W'(win_q[8]);
  assign sum2  = top_s + mid_s + bot_s;

  logic [SUM_W-1:0] sum3_q;
  logic [PIX_W-1:0] p3_q, e5_3_q, e7_3_q, e8_3_q;
  logic [CW-1:0]    r3_q, c3_q;
  res_sel_t         sel3_q;
  logic             v3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum3_q <= sum2;
      p3_q   <= win_q[4];
      e5_3_q <= win_q[5];
      e7_3_q <= win_q[7];
      e8_3_q <= win_q[8];
      r3_q   <= r2_q;
      c3_q   <= c2_q;
      sel3_q <= sel2_q;
    end
  end

  // ---------------------------------------------------------------- blur, mask
  logic [2*SUM_W-1:0] div_prod, div_shr;
  logic [PIX_W-1:0]   blur3, mask3;
  assign div_prod = (2*SUM_W)'(sum3_q) * (2*SUM_W)'(DIV9_MUL);
  assign div_shr  = div_prod >> DIV9_SHIFT;
  assign blur3    = div_shr[PIX_W-1:0];
  assign mask3    = (p3_q > blur3) ? p3_q - blur3 : '0;

  logic [PIX_W-1:0] mask4_q, p4_q, e5_4_q, e7_4_q, e8_4_q;
  logic [CW-1:0]    r4_q, c4_q;
  res_sel_t         sel4_q;
  logic             v4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mask4_q <= mask3;
      p4_q    <= p3_q;
      e5_4_q  <= e5_3_q;
      e7_4_q  <= e7_3_q;
      e8_4_q  <= e8_3_q;
      r4_q    <= r3_q;
      c4_q    <= c3_q;
      sel4_q  <= sel3_q;
    end
  end

  // ---------------------------------------------------------------- sharpen
  logic [2*PIX_W-1:0] gm4;
  logic [PIX_W:0]     add4;
  logic [PIX_W-1:0]   sharp4, centre4;
  assign gm4     = (2*PIX_W)'(gain_q) * (2*PIX_W)'(mask4_q);
  assign add4    = (PIX_W+1)'(p4_q) + (PIX_W+1)'(gm4[2*PIX_W-1:PIX_W]);
  assign sharp4  = add4[PIX_W] ? {PIX_W{1'b1}} : add4[PIX_W-1:0];
  assign centre4 = sel4_q.inner ? sharp4 : p4_q;

  // ---------------------------------------------------------------- stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------- result group
  logic [3:0]       grp_mask_q;
  logic [PIX_W-1:0] grp_pix_q [4];
  logic [CW-1:0]    grp_r_q, grp_c_q;

  logic             out_free, pop;
  logic [1:0]       pop_idx;
  logic [3:0]       mask_cleared, mask_after, grp_mask_d;

  always_comb begin
    priority if (grp_mask_q[0]) pop_idx = 2'd0;
    else if (grp_mask_q[1])     pop_idx = 2'd1;
    else if (grp_mask_q[2])     pop_idx = 2'd2;
    else                        pop_idx = 2'd3;
  end

  assign out_free     = !m_axis_tvalid || m_axis_tready;
  assign pop          = out_free && (grp_mask_q != '0);
  assign mask_cleared = grp_mask_q & ~(4'b0001 << pop_idx);
  assign mask_after   = pop ? mask_cleared : grp_mask_q;
  assign adv          = (mask_after == '0);
  assign grp_mask_d   = adv ? (v4_q ? sel4_q.sel : 4'b0000) : mask_after;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_mask_q <= '0;
    end else begin
      grp_mask_q <= grp_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      grp_pix_q[0] <= centre4;
      grp_pix_q[1] <= e5_4_q;
      grp_pix_q[2] <= e7_4_q;
      grp_pix_q[3] <= e8_4_q;
      grp_r_q      <= r4_q;
      grp_c_q      <= c4_q;
    end
  end

  // Results 0 and 1 belong to the row above, 0 and 2 to the column before
  logic [CW-1:0] pop_row, pop_col;
  assign pop_row = pop_idx[1] ? grp_r_q : grp_r_q - 1'b1;
  assign pop_col = pop_idx[0] ? grp_c_q : grp_c_q - 1'b1;

  // ---------------------------------------------------------------- output register
  logic                 out_valid_q, out_last_q;
  logic [PIX_W-1:0]     out_pix_q;
  logic [COORD_W-1:0]   out_row_q, out_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_pix_q  <= grp_pix_q[pop_idx];
      out_row_q  <= coord(pop_row);
      out_col_q  <= coord(pop_col);
      out_last_q <= (mask_cleared == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(M_TDATA_W - PIX_W - 2*COORD_W){1'b0}},
                          out_col_q, out_row_q, out_pix_q};

  // ---------------------------------------------------------------- checks
  // Consecutive pixels never touch the same line entry, so no forwarding.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && accept) |-> (c1_q != col_q))
    else $error("line memory read and write hit the same column");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= wlast_q) && (row_q <= hlast_q))
    else $error("position counter beyond frame geometry");

  a_stall_holds_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> (grp_mask_q != '0))
    else $error("input stalled with no results pending");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted pixel lost before the window stage");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !pop)
    else $error("result popped into a stalled output register");

endmodule

`default_nettype wire
